// ===== hdl/tftp_transfer_engine_macros.svh =====
// ----------------------------------------------------------------------------
// TFTP transfer engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef TFTP_TRANSFER_ENGINE_MACROS_SVH
`define TFTP_TRANSFER_ENGINE_MACROS_SVH

// Same-cycle implication.
`define TFTP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TFTP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tftp_pkg.sv =====
// ----------------------------------------------------------------------------
// TFTP transfer engine package
// Codes, constants and request/result structures shared by the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tftp_pkg;

  // Payload bytes in one full block, and full DATA packet size with header.
  localparam logic [9:0] BLOCK_BYTES     = 10'd512;
  localparam logic [9:0] FULL_PACKET_LEN = 10'd516;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [7:0]  RETRY_RESET   = 8'd5;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  // Request kinds.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_PACKET  = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  // Opcodes.
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;

  // Send kinds.
  localparam logic [1:0] SEND_NONE = 2'd0;
  localparam logic [1:0] SEND_DATA = 2'd1;
  localparam logic [1:0] SEND_ACK  = 2'd2;
  localparam logic [1:0] SEND_ERR  = 2'd3;

  // Error reasons.
  localparam logic [1:0] ERR_WRITE_FAILED  = 2'd0;
  localparam logic [1:0] ERR_INVALID_MODE  = 2'd1;
  localparam logic [1:0] ERR_NOT_FOUND     = 2'd2;
  localparam logic [1:0] ERR_CANNOT_CREATE = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] opcode;
    logic [15:0] rx_block;
    logic [9:0]  packet_length;
    logic        mode_ok;
    logic        file_ok;
    logic [9:0]  read_count;
  } item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [15:0] send_block;
    logic [9:0]  send_length;
    logic [1:0]  error_reason;
    logic        closed;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  retry_limit;
  } cfg_t;

  function automatic logic [9:0] clamp_read(input logic [9:0] rc);
    clamp_read = (rc > BLOCK_BYTES) ? BLOCK_BYTES : rc;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tftp_core.sv =====
// ----------------------------------------------------------------------------
// TFTP transfer core
// Transfer state and the combinational decision for one registered request.
// ----------------------------------------------------------------------------
`default_nettype none

module tftp_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire tftp_pkg::item_t item,
  input  wire tftp_pkg::cfg_t  cfg,
  output tftp_pkg::result_t    result
);

  logic        active,        active_next;
  logic        is_read,       is_read_next;
  logic [15:0] last_block,    last_block_next;
  logic [9:0]  last_size,     last_size_next;
  logic [7:0]  retries_left,  retries_left_next;
  logic [15:0] elapsed_ticks, elapsed_ticks_next;

  logic [15:0] elapsed_inc;
  logic [15:0] block_plus1;
  logic [9:0]  rc_clamped;
  logic        short_block;

  assign elapsed_inc = (elapsed_ticks != 16'hFFFF) ? elapsed_ticks + 16'd1 : elapsed_ticks;
  assign block_plus1 = last_block + 16'd1;
  assign rc_clamped  = tftp_pkg::clamp_read(item.read_count);
  assign short_block = item.packet_length < tftp_pkg::FULL_PACKET_LEN;

  always_comb begin
    result             = '0;
    active_next        = active;
    is_read_next       = is_read;
    last_block_next    = last_block;
    last_size_next     = last_size;
    retries_left_next  = retries_left;
    elapsed_ticks_next = elapsed_ticks;

    if (item.kind == tftp_pkg::KIND_REQUEST) begin
      if (item.opcode == tftp_pkg::OP_RRQ || item.opcode == tftp_pkg::OP_WRQ) begin
        // New transfer replaces any running one.
        active_next        = 1'b0;
        is_read_next       = (item.opcode == tftp_pkg::OP_RRQ);
        last_block_next    = '0;
        last_size_next     = '0;
        retries_left_next  = cfg.retry_limit;
        elapsed_ticks_next = '0;
        if (!item.mode_ok) begin
          result.send_kind    = tftp_pkg::SEND_ERR;
          result.error_reason = tftp_pkg::ERR_INVALID_MODE;
          result.closed       = 1'b1;
        end else if (!item.file_ok) begin
          result.send_kind    = tftp_pkg::SEND_ERR;
          result.error_reason = (item.opcode == tftp_pkg::OP_RRQ) ?
                                tftp_pkg::ERR_NOT_FOUND : tftp_pkg::ERR_CANNOT_CREATE;
          result.closed       = 1'b1;
        end else begin
          active_next = 1'b1;
          if (item.opcode == tftp_pkg::OP_RRQ) begin
            last_block_next    = 16'd1;
            last_size_next     = rc_clamped;
            result.send_kind   = tftp_pkg::SEND_DATA;
            result.send_block  = 16'd1;
            result.send_length = rc_clamped;
          end else begin
            result.send_kind = tftp_pkg::SEND_ACK;
          end
        end
      end
    end else if (active && item.kind == tftp_pkg::KIND_TICK) begin
      elapsed_ticks_next = elapsed_inc;
      if (elapsed_inc > cfg.timeout_ticks) begin
        if (retries_left > 8'd1) begin
          // Resend the last packet.
          retries_left_next  = retries_left - 8'd1;
          elapsed_ticks_next = '0;
          result.send_kind   = is_read ? tftp_pkg::SEND_DATA : tftp_pkg::SEND_ACK;
          result.send_block  = last_block;
          result.send_length = is_read ? last_size : '0;
        end else begin
          retries_left_next = '0;
          active_next       = 1'b0;
          result.closed     = 1'b1;
        end
      end
    end else if (active && item.kind == tftp_pkg::KIND_PACKET) begin
      case (item.opcode)
        tftp_pkg::OP_DATA: begin
          if (item.rx_block == block_plus1) begin
            retries_left_next = cfg.retry_limit;
            if (!item.file_ok) begin
              active_next         = 1'b0;
              result.send_kind    = tftp_pkg::SEND_ERR;
              result.error_reason = tftp_pkg::ERR_WRITE_FAILED;
              result.closed       = 1'b1;
            end else begin
              last_block_next    = item.rx_block;
              elapsed_ticks_next = '0;
              result.send_kind   = tftp_pkg::SEND_ACK;
              result.send_block  = item.rx_block;
              result.closed      = short_block;
              if (short_block) begin
                active_next = 1'b0;
              end
            end
          end
        end
        tftp_pkg::OP_ACK: begin
          if (item.rx_block == last_block) begin
            retries_left_next  = cfg.retry_limit;
            last_block_next    = block_plus1;
            last_size_next     = rc_clamped;
            elapsed_ticks_next = '0;
            result.send_kind   = tftp_pkg::SEND_DATA;
            result.send_block  = block_plus1;
            result.send_length = rc_clamped;
            // An empty block ends a read.
            if (rc_clamped == '0) begin
              active_next   = 1'b0;
              result.closed = 1'b1;
            end
          end
        end
        default: begin
          // ERROR or unknown opcode ends the transfer.
          active_next   = 1'b0;
          result.closed = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      is_read       <= 1'b0;
      last_block    <= '0;
      last_size     <= '0;
      retries_left  <= tftp_pkg::RETRY_RESET;
      elapsed_ticks <= '0;
    end else if (step) begin
      active        <= active_next;
      is_read       <= is_read_next;
      last_block    <= last_block_next;
      last_size     <= last_size_next;
      retries_left  <= retries_left_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tftp_transfer_engine.sv =====
// ----------------------------------------------------------------------------
// TFTP transfer engine
// Server-side control of one TFTP transfer: requests in, packets to send out.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per beat: tuser holds the kind (tick, start
//   request, received packet), tdata the opcode, block number, packet length,
//   mode/file status and the byte count read for the next block.
//   m_* returns exactly one result per request: tuser is the packet to send
//   (none, data, ack, error), tdata its block, length and error reason, and
//   tlast marks the request that ends the transfer.
//   cfg_* writes timeout_ticks (index 0) and retry_limit (index 1); write
//   only while no request is in flight.
// Timing: a request sits in an input register, is decided combinationally by
//   the core and lands in the result register once the result slot is free or
//   draining; m_tvalid comes from that register. One request is taken every
//   cycle while m_tready stays high.
// Reset: rst (synchronous) empties both registers, drops any transfer and
//   restores timeout_ticks 5000 and retry_limit 5.
// Stall: while m_tready is low the result holds; one more request can enter
//   the input register, after which s_tready drops until the result drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tftp_transfer_engine_macros.svh"

module tftp_transfer_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: opcode[15:0], rx_block[31:16], packet_length[41:32],
  //        mode_ok[42], file_ok[43], read_count[53:44], zero pad [55:54]
  input  wire logic [55:0] s_tdata,
  // tuser: kind[1:0]
  input  wire logic [1:0]  s_tuser,
  // Result channel.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: send_block[15:0], send_length[25:16], error_reason[27:26],
  //        zero pad [31:28]
  output logic [31:0]      m_tdata,
  // tuser: send_kind[1:0]
  output logic [1:0]       m_tuser,
  // tlast: closed
  output logic             m_tlast,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers.
  tftp_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= tftp_pkg::TIMEOUT_RESET;
      cfg.retry_limit   <= tftp_pkg::RETRY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tftp_pkg::CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        tftp_pkg::CFG_RETRY:   cfg.retry_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              in_valid;
  tftp_pkg::item_t   in_item;
  logic              advance;

  // Result register.
  logic              out_valid;
  tftp_pkg::result_t out_res;
  tftp_pkg::result_t core_res;

  // The decided request moves on whenever the result slot is free or draining.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind          <= s_tuser;
      in_item.opcode        <= s_tdata[15:0];
      in_item.rx_block      <= s_tdata[31:16];
      in_item.packet_length <= s_tdata[41:32];
      in_item.mode_ok       <= s_tdata[42];
      in_item.file_ok       <= s_tdata[43];
      in_item.read_count    <= s_tdata[53:44];
    end
  end

  tftp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.send_kind;
  assign m_tlast  = out_res.closed;
  assign m_tdata  = {4'b0000, out_res.error_reason, out_res.send_length, out_res.send_block};

  // An error packet always ends the transfer.
  `TFTP_ASSERT_IMP(a_err_closes, out_valid && out_res.send_kind == tftp_pkg::SEND_ERR,
                   out_res.closed, "error result without close")
  // Block and length are zero unless data or an ack goes out.
  `TFTP_ASSERT_IMP(a_idle_fields_zero,
                   out_valid && (out_res.send_kind == tftp_pkg::SEND_NONE ||
                                 out_res.send_kind == tftp_pkg::SEND_ERR),
                   out_res.send_block == '0 && out_res.send_length == '0,
                   "block or length set on a result without data or ack")
  // Data never exceeds one block.
  `TFTP_ASSERT_IMP(a_len_bound, out_valid, out_res.send_length <= tftp_pkg::BLOCK_BYTES,
                   "data length above block size")
  // A request waiting behind a stalled result stays in the input register.
  `TFTP_ASSERT_NXT(a_in_hold, in_valid && !advance, in_valid,
                   "pending request lost during stall")
  // A taken request always produces a result on the next edge.
  `TFTP_ASSERT_NXT(a_result_follows, advance, out_valid,
                   "decided request left no result")

endmodule

`default_nettype wire

// ===== test/tb_tftp_transfer_engine.sv =====
// ----------------------------------------------------------------------------
// TFTP transfer engine testbench
// Drives requests (ticks, start requests, received packets) into the engine,
// predicts every result with a behavioral copy of the transfer state, and
// compares each returned packet field by field. Directed cases cover ignored
// requests, request errors, both transfer directions and timeouts; random
// sessions follow under four pacing modes and several timeout/retry settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tftp_transfer_engine;

  // Opcodes the package leaves out.
  localparam logic [15:0] OP_ERROR   = 16'd5;
  localparam logic [15:0] OP_UNKNOWN = 16'h1234;

  // Cycles with no handshake on any channel before the run is abandoned.
  localparam int QUIET_LIMIT = 2000;
  // Extra wait once every result is back, before the verdict.
  localparam int DRAIN_CYCLES = 6;
  localparam int WORK_PER_PHASE = 85;

  typedef enum logic [1:0] {
    PACE_STEADY,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data  = '0;

  pace_t             pace_mode = PACE_STEADY;
  int                err_count = 0;
  int                work_items = 0;
  int                quiet_cycles = 0;
  tftp_pkg::result_t pending_results[$];

  // Predicted engine state and configuration.
  logic        eng_active;
  logic        eng_is_read;
  logic [15:0] eng_blk;
  logic [9:0]  eng_size;
  logic [7:0]  eng_retries;
  logic [15:0] eng_elapsed;
  logic [15:0] eng_timeout;
  logic [7:0]  eng_retry_limit;

  tftp_transfer_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    // tdata: opcode, rx_block, packet_length, mode_ok, file_ok, read_count
    .s_tdata   (s_tdata),
    // tuser: kind
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    // tdata: send_block, send_length, error_reason
    .m_tdata   (m_tdata),
    // tuser: send_kind
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction: one result per accepted request, state updated in place.
  // --------------------------------------------------------------------------
  function automatic tftp_pkg::result_t engine_respond(input tftp_pkg::item_t it);
    tftp_pkg::result_t r;
    logic [9:0]        n;
    logic [15:0]       next_blk;
    r = '0;
    n = (it.read_count > tftp_pkg::BLOCK_BYTES) ? tftp_pkg::BLOCK_BYTES : it.read_count;
    next_blk = eng_blk + 16'd1;

    if (it.kind == tftp_pkg::KIND_REQUEST) begin
      // Only RRQ/WRQ start anything; other opcodes leave the state alone.
      if (it.opcode != tftp_pkg::OP_RRQ && it.opcode != tftp_pkg::OP_WRQ) return r;
      // Any running transfer is dropped.
      eng_active  = 1'b0;
      eng_is_read = (it.opcode == tftp_pkg::OP_RRQ);
      eng_blk     = '0;
      eng_size    = '0;
      eng_retries = eng_retry_limit;
      eng_elapsed = '0;
      if (!it.mode_ok) begin
        r.send_kind    = tftp_pkg::SEND_ERR;
        r.error_reason = tftp_pkg::ERR_INVALID_MODE;
        r.closed       = 1'b1;
      end else if (!it.file_ok) begin
        r.send_kind    = tftp_pkg::SEND_ERR;
        r.error_reason = eng_is_read ? tftp_pkg::ERR_NOT_FOUND : tftp_pkg::ERR_CANNOT_CREATE;
        r.closed       = 1'b1;
      end else begin
        eng_active = 1'b1;
        if (eng_is_read) begin
          eng_blk       = 16'd1;
          eng_size      = n;
          r.send_kind   = tftp_pkg::SEND_DATA;
          r.send_block  = 16'd1;
          r.send_length = n;
        end else begin
          r.send_kind = tftp_pkg::SEND_ACK;
        end
      end
      return r;
    end

    if (!eng_active || it.kind == tftp_pkg::KIND_UNUSED) return r;

    if (it.kind == tftp_pkg::KIND_TICK) begin
      // Saturating timer; timeout only once it strictly exceeds the limit.
      if (eng_elapsed != 16'hFFFF) eng_elapsed = eng_elapsed + 16'd1;
      if (eng_elapsed <= eng_timeout) return r;
      if (eng_retries > 8'd1) begin
        eng_retries  = eng_retries - 8'd1;
        eng_elapsed  = '0;
        r.send_block = eng_blk;
        if (eng_is_read) begin
          r.send_kind   = tftp_pkg::SEND_DATA;
          r.send_length = eng_size;
        end else begin
          r.send_kind = tftp_pkg::SEND_ACK;
        end
      end else begin
        eng_retries = '0;
        eng_active  = 1'b0;
        r.closed    = 1'b1;
      end
      return r;
    end

    // Received packet; no check of transfer direction.
    case (it.opcode)
      tftp_pkg::OP_DATA: begin
        if (it.rx_block == next_blk) begin
          eng_retries = eng_retry_limit;
          if (!it.file_ok) begin
            eng_active     = 1'b0;
            r.send_kind    = tftp_pkg::SEND_ERR;
            r.error_reason = tftp_pkg::ERR_WRITE_FAILED;
            r.closed       = 1'b1;
          end else begin
            eng_blk      = it.rx_block;
            eng_elapsed  = '0;
            r.send_kind  = tftp_pkg::SEND_ACK;
            r.send_block = it.rx_block;
            if (it.packet_length < tftp_pkg::FULL_PACKET_LEN) begin
              eng_active = 1'b0;
              r.closed   = 1'b1;
            end
          end
        end
      end
      tftp_pkg::OP_ACK: begin
        if (it.rx_block == eng_blk) begin
          eng_retries   = eng_retry_limit;
          eng_blk       = next_blk;
          eng_size      = n;
          eng_elapsed   = '0;
          r.send_kind   = tftp_pkg::SEND_DATA;
          r.send_block  = next_blk;
          r.send_length = n;
          // Empty block ends a read.
          if (n == 10'd0) begin
            eng_active = 1'b0;
            r.closed   = 1'b1;
          end
        end
      end
      default: begin
        // ERROR and unknown opcodes close the transfer.
        eng_active = 1'b0;
        r.closed   = 1'b1;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request channel driver. Called and returns at a falling edge.
  // --------------------------------------------------------------------------
  function automatic bit sender_pauses();
    case (pace_mode)
      PACE_SENDER_IDLE: return $urandom_range(0, 99) < 81;
      PACE_BOTH:        return $urandom_range(0, 99) < 8;
      default:          return 1'b0;
    endcase
  endfunction

  task automatic send_item(input tftp_pkg::item_t it);
    while (sender_pauses()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {2'b00, it.read_count, it.file_ok, it.mode_ok, it.packet_length,
                 it.rx_block, it.opcode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // Kind 3 requests, and any but an RRQ/WRQ start while idle, are not counted as work.
    if (it.kind != tftp_pkg::KIND_UNUSED &&
        (eng_active || (it.kind == tftp_pkg::KIND_REQUEST &&
                        (it.opcode == tftp_pkg::OP_RRQ || it.opcode == tftp_pkg::OP_WRQ))))
      work_items++;
    pending_results.push_back(engine_respond(it));
    @(negedge clk);
  endtask

  // Register write, only once every result is back and the pipe is quiet.
  task automatic write_reg(input logic idx, input logic [15:0] value);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tftp_pkg::CFG_TIMEOUT) eng_timeout = value;
    else eng_retry_limit = value[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic tftp_pkg::item_t make_item(input logic [1:0] kind,
                                                input logic [15:0] op,
                                                input logic [15:0] blk,
                                                input logic [9:0] plen,
                                                input logic mode, input logic file,
                                                input logic [9:0] rc);
    tftp_pkg::item_t it;
    it.kind          = kind;
    it.opcode        = op;
    it.rx_block      = blk;
    it.packet_length = plen;
    it.mode_ok       = mode;
    it.file_ok       = file;
    it.read_count    = rc;
    return it;
  endfunction

  function automatic tftp_pkg::item_t rand_item();
    tftp_pkg::item_t it;
    it.kind          = 2'($urandom_range(0, 3));
    it.opcode        = ($urandom_range(0, 1) == 1) ? 16'($urandom) :
                                                     16'($urandom_range(0, 6));
    it.rx_block      = 16'($urandom);
    it.packet_length = 10'($urandom);
    it.mode_ok       = 1'($urandom);
    it.file_ok       = 1'($urandom);
    it.read_count    = 10'($urandom);
    return it;
  endfunction

  function automatic logic [9:0] pick_read_count();
    case ($urandom_range(0, 9))
      0:       return 10'd0;
      1:       return 10'($urandom_range(1, 511));
      2:       return 10'($urandom_range(513, 1023));
      default: return tftp_pkg::BLOCK_BYTES;
    endcase
  endfunction

  function automatic logic [9:0] pick_packet_len();
    case ($urandom_range(0, 9))
      0, 1:    return 10'($urandom_range(0, 515));
      2:       return 10'($urandom_range(517, 1023));
      default: return tftp_pkg::FULL_PACKET_LEN;
    endcase
  endfunction

  // Occasional ticks; sometimes a burst long enough to force a timeout.
  task automatic maybe_ticks();
    int              n;
    tftp_pkg::item_t it;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: n = 0;
      6, 7, 8:          n = $urandom_range(1, 3);
      default: n = (eng_timeout < 16'd40) ? int'(eng_timeout) + $urandom_range(1, 3)
                                          : $urandom_range(4, 10);
    endcase
    repeat (n) begin
      it = rand_item();
      it.kind = tftp_pkg::KIND_TICK;
      send_item(it);
    end
  endtask

  task automatic rand_read_session();
    tftp_pkg::item_t it;
    int              steps;
    it = rand_item();
    it.kind    = tftp_pkg::KIND_REQUEST;
    it.opcode  = tftp_pkg::OP_RRQ;
    it.mode_ok = ($urandom_range(0, 15) != 0);
    it.file_ok = ($urandom_range(0, 15) != 0);
    it.read_count = pick_read_count();
    send_item(it);
    steps = $urandom_range(1, 16);
    while (eng_active && steps > 0) begin
      maybe_ticks();
      it = rand_item();
      it.kind       = tftp_pkg::KIND_PACKET;
      it.opcode     = ($urandom_range(0, 19) == 0) ? tftp_pkg::OP_DATA : tftp_pkg::OP_ACK;
      it.read_count = pick_read_count();
      case ($urandom_range(0, 9))
        0:       it.rx_block = eng_blk - 16'd1;  // stale ack
        1:       it.rx_block = eng_blk + 16'd1;
        default: it.rx_block = (it.opcode == tftp_pkg::OP_DATA) ? eng_blk + 16'd1 : eng_blk;
      endcase
      send_item(it);
      steps--;
    end
  endtask

  task automatic rand_write_session();
    tftp_pkg::item_t it;
    int              steps;
    it = rand_item();
    it.kind    = tftp_pkg::KIND_REQUEST;
    it.opcode  = tftp_pkg::OP_WRQ;
    it.mode_ok = ($urandom_range(0, 15) != 0);
    it.file_ok = ($urandom_range(0, 15) != 0);
    send_item(it);
    steps = $urandom_range(1, 16);
    while (eng_active && steps > 0) begin
      maybe_ticks();
      it = rand_item();
      it.kind          = tftp_pkg::KIND_PACKET;
      it.opcode        = tftp_pkg::OP_DATA;
      it.file_ok       = ($urandom_range(0, 19) != 0);
      it.packet_length = pick_packet_len();
      if ($urandom_range(0, 9) == 0)
        it.rx_block = eng_blk + (($urandom_range(0, 1) == 1) ? 16'd2 : 16'd0);
      else
        it.rx_block = eng_blk + 16'd1;
      send_item(it);
      steps--;
    end
  endtask

  // Start request followed by packets with odd opcodes and near-miss blocks.
  task automatic rand_broken_session();
    tftp_pkg::item_t it;
    it = rand_item();
    it.kind   = tftp_pkg::KIND_REQUEST;
    it.opcode = ($urandom_range(0, 1) == 1) ? tftp_pkg::OP_RRQ : tftp_pkg::OP_WRQ;
    send_item(it);
    repeat ($urandom_range(1, 6)) begin
      it = rand_item();
      if ($urandom_range(0, 1) == 1) begin
        it.kind     = tftp_pkg::KIND_PACKET;
        it.opcode   = 16'($urandom_range(0, 7));
        it.rx_block = eng_blk + 16'($urandom_range(0, 2));
      end
      send_item(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Nothing running: ticks, packets, kind 3 and bad request opcodes are ignored.
  task automatic test_idle_items();
    send_item(make_item(tftp_pkg::KIND_TICK, 16'd0, 16'd0, 10'd0, 1'b0, 1'b0, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_ACK, 16'hFFFF, 10'h3FF,
                        1'b1, 1'b1, 10'h3FF));
    send_item(make_item(tftp_pkg::KIND_UNUSED, tftp_pkg::OP_RRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd10));
    send_item(make_item(tftp_pkg::KIND_REQUEST, 16'hFFFF, 16'd1, 10'd4, 1'b1, 1'b1, 10'd1));
  endtask

  // Bad mode, missing or uncreatable file, and a clamped first block.
  task automatic test_request_outcomes();
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_RRQ, 16'd0, 10'd0,
                        1'b0, 1'b1, 10'd5));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_WRQ, 16'd0, 10'd0,
                        1'b0, 1'b0, 10'd5));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_RRQ, 16'd0, 10'd0,
                        1'b1, 1'b0, 10'd5));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_WRQ, 16'd0, 10'd0,
                        1'b1, 1'b0, 10'd5));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_RRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'h3FF));
  endtask

  // Write transfer: starts over the running read, wrong block, ACK in a write,
  // oversized DATA, failed write, then a short block closing a second write.
  task automatic test_write_path();
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_WRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_DATA, 16'd5,
                        tftp_pkg::FULL_PACKET_LEN, 1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_ACK, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd100));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_DATA, 16'd2, 10'h3FF,
                        1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_DATA, 16'd3,
                        tftp_pkg::FULL_PACKET_LEN, 1'b1, 1'b0, 10'd0));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_WRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_DATA, 16'd1, 10'd515,
                        1'b1, 1'b1, 10'd0));
  endtask

  // Read transfer: DATA in a read, stale ack, clamp, empty final block.
  task automatic test_read_path();
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_RRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, tftp_pkg::BLOCK_BYTES));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_DATA, 16'd2,
                        tftp_pkg::FULL_PACKET_LEN, 1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_ACK, 16'd1, 10'd4,
                        1'b1, 1'b1, 10'd9));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_ACK, 16'd2, 10'd4,
                        1'b1, 1'b1, 10'd600));
    send_item(make_item(tftp_pkg::KIND_PACKET, tftp_pkg::OP_ACK, 16'd3, 10'd4,
                        1'b1, 1'b1, 10'd0));
  endtask

  // Resend on timeout, close when retries run out; ERROR and unknown opcodes.
  task automatic test_timeout_retry();
    write_reg(tftp_pkg::CFG_TIMEOUT, 16'd1);
    write_reg(tftp_pkg::CFG_RETRY, 16'd2);
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_RRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd7));
    repeat (4) send_item(make_item(tftp_pkg::KIND_TICK, 16'd0, 16'd0, 10'd0,
                                   1'b0, 1'b0, 10'd0));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_WRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, OP_ERROR, 16'd0, 10'd4, 1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_REQUEST, tftp_pkg::OP_WRQ, 16'd0, 10'd0,
                        1'b1, 1'b1, 10'd0));
    send_item(make_item(tftp_pkg::KIND_PACKET, OP_UNKNOWN, 16'd0, 10'd4, 1'b1, 1'b1, 10'd0));
  endtask

  task automatic test_random_traffic(input pace_t pace, input logic [15:0] tmo,
                                     input logic [15:0] rty);
    int goal;
    write_reg(tftp_pkg::CFG_TIMEOUT, tmo);
    write_reg(tftp_pkg::CFG_RETRY, rty);
    pace_mode = pace;
    goal = work_items + WORK_PER_PHASE;
    while (work_items < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rand_read_session();
        4, 5, 6, 7: rand_write_session();
        8:          repeat (4) send_item(rand_item());
        default:    rand_broken_session();
      endcase
    end
    pace_mode = PACE_STEADY;
  endtask

  // --------------------------------------------------------------------------
  // Result channel: backpressure and checking.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    case (pace_mode)
      PACE_RECEIVER_STALL: m_tready <= ($urandom_range(0, 99) >= 81);
      PACE_BOTH:           m_tready <= ($urandom_range(0, 99) >= 8);
      default:             m_tready <= 1'b1;
    endcase
  end

  function automatic void check_field(input string what, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    tftp_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                 $time, m_tuser, m_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("send_kind", 16'(want.send_kind), 16'(m_tuser));
        check_field("send_block", want.send_block, m_tdata[15:0]);
        check_field("send_length", 16'(want.send_length), 16'(m_tdata[25:16]));
        check_field("error_reason", 16'(want.error_reason), 16'(m_tdata[27:26]));
        check_field("closed", 16'(want.closed), 16'(m_tlast));
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    eng_timeout     = tftp_pkg::TIMEOUT_RESET;
    eng_retry_limit = tftp_pkg::RETRY_RESET;
    eng_active      = 1'b0;
    eng_is_read     = 1'b0;
    eng_blk         = '0;
    eng_size        = '0;
    eng_retries     = tftp_pkg::RETRY_RESET;
    eng_elapsed     = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_idle_items();
    test_request_outcomes();
    test_write_path();
    test_read_path();
    test_timeout_retry();
    test_random_traffic(PACE_STEADY, 16'd3, 16'd2);
    test_random_traffic(PACE_SENDER_IDLE, 16'd1, 16'd1);
    test_random_traffic(PACE_RECEIVER_STALL, 16'hFFFF, 16'h5AFF);
    test_random_traffic(PACE_BOTH, 16'($urandom_range(1, 24)),
                        {8'($urandom_range(0, 255)), 8'($urandom_range(1, 8))});

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
